FILE: rtl/mi3_pkg.sv
// Shared types and constants for the 3x3 matrix inverse core.
package mi3_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned N_ELEM = 9;
  // A cofactor is a difference of two element products.
  localparam int unsigned COF_W = 2 * ELEM_W + 1;
  // The determinant is a sum of three element-by-cofactor products.
  localparam int unsigned DET_W = 3 * ELEM_W + 2;

  // Operand indexes (row * 3 + col) for cofactor i = a[A]*a[B] - a[C]*a[D].
  localparam int unsigned COF_A [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int unsigned COF_B [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int unsigned COF_C [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int unsigned COF_D [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef struct packed {
    logic signed [ELEM_W-1:0] a00;
    logic signed [ELEM_W-1:0] a01;
    logic signed [ELEM_W-1:0] a02;
    logic signed [ELEM_W-1:0] a10;
    logic signed [ELEM_W-1:0] a11;
    logic signed [ELEM_W-1:0] a12;
    logic signed [ELEM_W-1:0] a20;
    logic signed [ELEM_W-1:0] a21;
    logic signed [ELEM_W-1:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] inv00;
    logic signed [ELEM_W-1:0] inv01;
    logic signed [ELEM_W-1:0] inv02;
    logic signed [ELEM_W-1:0] inv10;
    logic signed [ELEM_W-1:0] inv11;
    logic signed [ELEM_W-1:0] inv12;
    logic signed [ELEM_W-1:0] inv20;
    logic signed [ELEM_W-1:0] inv21;
    logic signed [ELEM_W-1:0] inv22;
    logic                     singular;
  } out_t;

  // Exact adjugate and determinant handed from front to back.
  typedef struct packed {
    logic [N_ELEM-1:0][COF_W-1:0] cof;
    logic [DET_W-1:0]             det;
  } cofdet_t;

endpackage

FILE: rtl/mi3_front.sv
// Front pipeline: accept a matrix, form the exact cofactors and determinant.
module mi3_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mi3_pkg::in_t    item_i,
  output logic            full_o,
  input  logic            q_full_i,
  output logic            q_push_o,
  output mi3_pkg::cofdet_t q_data_o
);
  localparam int unsigned W   = mi3_pkg::ELEM_W;
  localparam int unsigned N   = mi3_pkg::N_ELEM;
  localparam int unsigned CW  = mi3_pkg::COF_W;
  localparam int unsigned DW  = mi3_pkg::DET_W;
  localparam int unsigned PW  = 2 * W;
  // Cofactor split: low part unsigned, high part signed.
  localparam int unsigned LO  = W + 1;
  localparam int unsigned HI  = CW - LO;
  localparam int unsigned PLW = W + LO + 1;
  localparam int unsigned PHW = W + HI;

  logic signed [W-1:0] e [N];
  logic en;
  logic v1_q, v2_q, v3_q, v4_q;

  logic signed [PW-1:0]  p1_q [N], p2_q [N], p1_d [N], p2_d [N];
  logic signed [W-1:0]   ac1_q [3], ac2_q [3];
  logic signed [CW-1:0]  cof2_q [N], cof2_d [N], cof3_q [N];
  logic signed [PLW-1:0] plo_q [3], plo_d [3];
  logic signed [PHW-1:0] phi_q [3], phi_d [3];
  logic signed [DW-1:0]  det_q, det_d;
  logic [N-1:0][CW-1:0]  cof4_q;

  assign en       = !v4_q || !q_full_i;
  assign full_o   = !en;
  assign q_push_o = v4_q && !q_full_i;
  assign q_data_o = '{cof: cof4_q, det: det_q};

  always_comb begin
    e[0] = item_i.a00; e[1] = item_i.a01; e[2] = item_i.a02;
    e[3] = item_i.a10; e[4] = item_i.a11; e[5] = item_i.a12;
    e[6] = item_i.a20; e[7] = item_i.a21; e[8] = item_i.a22;
    for (int i = 0; i < N; i++) begin
      p1_d[i] = PW'(e[mi3_pkg::COF_A[i]]) * PW'(e[mi3_pkg::COF_B[i]]);
      p2_d[i] = PW'(e[mi3_pkg::COF_C[i]]) * PW'(e[mi3_pkg::COF_D[i]]);
      cof2_d[i] = CW'(p1_q[i]) - CW'(p2_q[i]);
    end
    // Expand along the first column: a00*c0 + a10*c1 + a20*c2.
    for (int j = 0; j < 3; j++) begin
      plo_d[j] = PLW'(ac2_q[j]) * $signed({1'b0, cof2_q[j][LO-1:0]});
      phi_d[j] = PHW'(ac2_q[j]) * PHW'($signed(cof2_q[j][CW-1:LO]));
    end
    det_d = '0;
    for (int j = 0; j < 3; j++) begin
      det_d = det_d + (DW'(phi_q[j]) <<< LO) + DW'(plo_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q  <= p1_d;
      p2_q  <= p2_d;
      ac1_q <= '{e[0], e[3], e[6]};
      cof2_q <= cof2_d;
      ac2_q <= ac1_q;
      plo_q <= plo_d;
      phi_q <= phi_d;
      cof3_q <= cof2_q;
      det_q <= det_d;
      for (int i = 0; i < N; i++) begin
        cof4_q[i] <= cof3_q[i];
      end
    end
  end

endmodule

FILE: rtl/mi3_fifo.sv
// Small register queue between the front and back pipelines.
module mi3_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/mi3_back.sv
// Back pipeline: nine restoring dividers, one quotient bit per stage, saturate.
module mi3_back #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  mi3_pkg::cofdet_t q_data_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output mi3_pkg::out_t    result_o
);
  localparam int unsigned W  = mi3_pkg::ELEM_W;
  localparam int unsigned N  = mi3_pkg::N_ELEM;
  localparam int unsigned CW = mi3_pkg::COF_W;
  localparam int unsigned DW = mi3_pkg::DET_W;
  localparam int unsigned NW = CW + 2 * FRAC_BITS;
  localparam int unsigned XW = DW + W;
  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  logic en;

  // Entry stage: magnitudes and signs.
  logic             v0_q;
  logic [XW-1:0]    nabs0_q [N], nabs0_d [N];
  logic             neg0_q [N], neg0_d [N];
  logic [DW-1:0]    dabs0_q, dabs0_d;
  logic             sing0_q, sing0_d;

  // Divide stages; stage 0 holds the overflow check.
  logic             v_q    [W];
  logic [XW-1:0]    rem_q  [W][N], rem_d  [W][N];
  logic [W-2:0]     quo_q  [W][N], quo_d  [W][N];
  logic             neg_q  [W][N], ovf_q  [W][N], ovf_d [N];
  logic [DW-1:0]    dabs_q [W];
  logic             sing_q [W];

  logic             out_v_q;
  logic [W-1:0]     res [N];
  mi3_pkg::out_t    out_q, out_d;

  assign en       = !out_v_q || pop_i;
  assign q_pop_o  = en && !q_empty_i;
  assign empty_o  = !out_v_q;
  assign result_o = out_q;

  always_comb begin
    logic signed [CW-1:0] cof;
    logic signed [NW-1:0] num;
    logic signed [DW-1:0] det;
    logic [XW-1:0]        sub;
    logic [W-1:0]         qx;
    det      = $signed(q_data_i.det);
    dabs0_d  = det[DW-1] ? $unsigned(-det) : $unsigned(det);
    sing0_d  = (det == '0);
    for (int l = 0; l < N; l++) begin
      cof        = $signed(q_data_i.cof[l]);
      num        = NW'(cof) <<< (2 * FRAC_BITS);
      nabs0_d[l] = XW'(num[NW-1] ? $unsigned(-num) : $unsigned(num));
      neg0_d[l]  = cof[CW-1] ^ det[DW-1];
      ovf_d[l]   = nabs0_q[l] >= (XW'(dabs0_q) << (W - 1));
      rem_d[0][l] = nabs0_q[l];
      quo_d[0][l] = '0;
    end
    for (int s = 0; s < W - 1; s++) begin
      for (int l = 0; l < N; l++) begin
        sub = XW'(dabs_q[s]) << (W - 2 - s);
        if (rem_q[s][l] >= sub) begin
          rem_d[s+1][l] = rem_q[s][l] - sub;
          quo_d[s+1][l] = quo_q[s][l] | ((W-1)'(1) << (W - 2 - s));
        end else begin
          rem_d[s+1][l] = rem_q[s][l];
          quo_d[s+1][l] = quo_q[s][l];
        end
      end
    end
    for (int l = 0; l < N; l++) begin
      qx = {1'b0, quo_q[W-1][l]};
      if (sing_q[W-1]) begin
        res[l] = '0;
      end else if (ovf_q[W-1][l]) begin
        res[l] = neg_q[W-1][l] ? SAT_MIN : SAT_MAX;
      end else begin
        res[l] = neg_q[W-1][l] ? -qx : qx;
      end
    end
    out_d.inv00 = res[0]; out_d.inv01 = res[1]; out_d.inv02 = res[2];
    out_d.inv10 = res[3]; out_d.inv11 = res[4]; out_d.inv12 = res[5];
    out_d.inv20 = res[6]; out_d.inv21 = res[7]; out_d.inv22 = res[8];
    out_d.singular = sing_q[W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int s = 0; s < W; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (en) begin
      v0_q    <= !q_empty_i;
      v_q[0]  <= v0_q;
      for (int s = 1; s < W; s++) begin
        v_q[s] <= v_q[s-1];
      end
      out_v_q <= v_q[W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nabs0_q <= nabs0_d;
      neg0_q  <= neg0_d;
      dabs0_q <= dabs0_d;
      sing0_q <= sing0_d;
      dabs_q[0] <= dabs0_q;
      sing_q[0] <= sing0_q;
      for (int l = 0; l < N; l++) begin
        neg_q[0][l] <= neg0_q[l];
        ovf_q[0][l] <= ovf_d[l];
      end
      for (int s = 0; s < W; s++) begin
        for (int l = 0; l < N; l++) begin
          rem_q[s][l] <= rem_d[s][l];
          quo_q[s][l] <= quo_d[s][l];
        end
      end
      for (int s = 1; s < W; s++) begin
        dabs_q[s] <= dabs_q[s-1];
        sing_q[s] <= sing_q[s-1];
        for (int l = 0; l < N; l++) begin
          neg_q[s][l] <= neg_q[s-1][l];
          ovf_q[s][l] <= ovf_q[s-1][l];
        end
      end
      out_q <= out_d;
    end
  end

endmodule

FILE: rtl/matrix_inverse_3x3_core.sv
// Top level of the 3x3 fixed-point matrix inverse core.
//
// Usage: write one 3x3 matrix of signed Q16.16 elements on item_i and raise
// push; the matrix is taken on a rising edge with push high and full low.
// Each matrix yields one result: nine saturated Q16.16 inverse elements and
// a singular flag (all elements zero when the determinant is zero). The
// oldest result sits on result_o while empty is low; take it by raising pop.
// Throughput: one matrix per cycle, sustained, while results are drained.
// The input transfer loads the first of four front stages (products,
// cofactors, split determinant products, sum); the front result then
// passes through the queue and 34 back stages: magnitudes, overflow check,
// one restoring-divider stage per quotient bit (31), output register.
// The quotient-bit stages set the depth; the multipliers set the front.
// When the receiver stalls, the back pipeline holds; the queue absorbs
// front results until it fills, then full rises and input transfers stop.
// Reset clears all valid state: empty is high and full low; no clearing pass.
module matrix_inverse_3x3_core #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  mi3_pkg::in_t  item_i,
  output logic          empty,
  input  logic          pop,
  output mi3_pkg::out_t result_o
);
  localparam int unsigned QW = $bits(mi3_pkg::cofdet_t);

  logic             q_push, q_full, q_pop, q_empty;
  mi3_pkg::cofdet_t q_wdata, q_rdata;
  logic [QW-1:0]    q_rdata_raw;

  // Front: accept and form the exact adjugate and determinant.
  mi3_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (item_i),
    .full_o   (full),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // Decouple the two halves so each can stall on its own.
  mi3_fifo #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata_raw),
    .empty_o (q_empty)
  );

  assign q_rdata = mi3_pkg::cofdet_t'(q_rdata_raw);

  // Back: divide each cofactor by the determinant and saturate.
  mi3_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rdata),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result_o)
  );

endmodule

FILE: rtl/mi3_checker.sv
// Port-level checker for the matrix inverse core, bound to the top level.
module mi3_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input mi3_pkg::out_t result_o
);

  // Check in the cycle after reset is seen, once the flops have been cleared.
  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result queue not empty during reset");

  a_rst_full: assert property (@(posedge clk_i) !rst_ni |=> !full)
    else $error("input reports full during reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed before transfer");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.singular) |->
      (result_o.inv00 == '0 && result_o.inv01 == '0 && result_o.inv02 == '0 &&
       result_o.inv10 == '0 && result_o.inv11 == '0 && result_o.inv12 == '0 &&
       result_o.inv20 == '0 && result_o.inv21 == '0 && result_o.inv22 == '0))
    else $error("singular result carries nonzero elements");

endmodule

bind matrix_inverse_3x3_core mi3_checker u_mi3_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
